// File: src/irdig_pkg.sv
// irdig_pkg: shared types, constants and functions for the radix digit converter
// no dependencies; imported by irdig_front, irdig_back, integer_to_radix_digits_top and testbench

package irdig_pkg;

	localparam int RADIX_W   = 6;
	localparam int DIGIT_W   = 6;
	localparam int CHAR_W    = 7;
	localparam int STEP_BITS = 4;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 6'd35;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_NUM_OFS   = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFS = 7'd55;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_EMIT
	} back_state_t;

	// bases outside two to thirty-six are pulled to the nearest end
	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	// digit to ascii: '0'-'9' then 'A'-'Z'
	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] c;
		logic [CHAR_W-1:0]  res;
		c = (d > DIGIT_MAX) ? DIGIT_MAX : d;
		if (c < DIGIT_TEN) begin
			res = CHAR_NUM_OFS + {1'b0, c};
		end else begin
			res = CHAR_ALPHA_OFS + {1'b0, c};
		end
		return res;
	endfunction

endpackage

// File: src/irdig_front.sv
// irdig_front: input side; takes words, clamps the base and holds them in a
// two-entry queue for the back end. depends on irdig_pkg

module irdig_front
	import irdig_pkg::*;
#(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]    radix,
	output logic                  item_valid,
	input  logic                  item_ready,
	output logic [VALUE_BITS-1:0] item_value,
	output logic [RADIX_W-1:0]    item_radix
);

	logic [VALUE_BITS-1:0] val_q [2];
	logic [RADIX_W-1:0]    rad_q [2];
	logic                  wp_q;
	logic                  rp_q;
	logic [1:0]            cnt_q;
	logic                  wr_en;
	logic                  rd_en;

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign wr_en      = push && !full;
	assign rd_en      = item_valid && item_ready;
	assign item_value = val_q[rp_q];
	assign item_radix = rad_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= !wp_q;
			end
			if (rd_en) begin
				rp_q <= !rp_q;
			end
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			val_q[wp_q] <= value;
			rad_q[wp_q] <= clamp_radix(radix);
		end
	end

endmodule

// File: src/irdig_back.sv
// irdig_back: iterative divider, digit store and digit emission with a
// two-entry output queue. depends on irdig_pkg

module irdig_back
	import irdig_pkg::*;
#(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic [VALUE_BITS-1:0] item_value,
	input  logic [RADIX_W-1:0]    item_radix,
	output logic                  empty,
	input  logic                  pop,
	output logic [CHAR_W-1:0]     digit_char,
	output logic                  last
);

	localparam int IDX_W = $clog2(VALUE_BITS);
	localparam int CNT_W = $clog2(VALUE_BITS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(VALUE_BITS);
	localparam logic [CNT_W-1:0] CNT_STEP = CNT_W'(STEP_BITS);

	back_state_t state_q;
	back_state_t state_nx;

	logic [VALUE_BITS-1:0] quot_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [RADIX_W-1:0]    rad_q;
	logic [CNT_W-1:0]      pos_q;
	logic [CNT_W-1:0]      width_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      rd_idx_q;

	logic [VALUE_BITS-1:0] quot_nx;
	logic [DIGIT_W-1:0]    rem_nx;
	logic [CNT_W-1:0]      pos_nx;
	logic                  start;
	logic                  div_end;
	logic                  conv_end;
	logic                  issue;

	// digit store
	logic [DIGIT_W-1:0] store_mem [VALUE_BITS];
	logic [DIGIT_W-1:0] rd_data_s1;
	logic               pend_s1;
	logic               last_s1;

	// output queue
	logic [CHAR_W-1:0] oq_char_q [2];
	logic              oq_last_q [2];
	logic              oq_wp_q;
	logic              oq_rp_q;
	logic [1:0]        oq_cnt_q;
	logic [1:0]        oq_used;
	logic              pop_fire;

	assign item_ready = (state_q == BK_IDLE);
	assign start      = item_valid && item_ready;
	assign empty      = (oq_cnt_q == 2'd0);
	assign pop_fire   = pop && !empty;
	assign digit_char = oq_char_q[oq_rp_q];
	assign last       = oq_last_q[oq_rp_q];
	assign oq_used    = oq_cnt_q + {1'b0, pend_s1};
	assign issue      = (state_q == BK_EMIT) && ((oq_used < 2'd2) || pop_fire);

	// up to four restoring division steps per cycle, quotient bits in place
	always_comb begin
		logic [DIGIT_W:0]   t;
		logic [IDX_W-1:0]   idx;
		t       = '0;
		idx     = '0;
		quot_nx = quot_q;
		rem_nx  = rem_q;
		for (int j = 0; j < STEP_BITS; j++) begin
			if (pos_q > CNT_W'(j)) begin
				idx = IDX_W'(pos_q - CNT_W'(j) - CNT_W'(1));
				t   = {rem_nx, quot_nx[idx]};
				if (t >= {1'b0, rad_q}) begin
					t            = t - {1'b0, rad_q};
					quot_nx[idx] = 1'b1;
				end else begin
					quot_nx[idx] = 1'b0;
				end
				rem_nx = t[DIGIT_W-1:0];
			end
		end
		pos_nx = (pos_q > CNT_STEP) ? (pos_q - CNT_STEP) : '0;
	end

	assign div_end  = (state_q == BK_DIV) && (pos_nx == '0);
	assign conv_end = div_end && (quot_nx == '0);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (start) begin
					state_nx = BK_DIV;
				end
			end
			BK_DIV: begin
				if (conv_end) begin
					state_nx = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (issue && (rd_idx_q == '0)) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pos_q    <= '0;
			width_q  <= '0;
			rd_idx_q <= '0;
		end else begin
			if (start) begin
				cnt_q   <= '0;
				pos_q   <= CNT_FULL;
				width_q <= CNT_FULL;
			end else if (state_q == BK_DIV) begin
				if (div_end) begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (conv_end) begin
						rd_idx_q <= cnt_q[IDX_W-1:0];
					end else begin
						// quotient lost at least one bit of width
						width_q <= width_q - CNT_W'(1);
						pos_q   <= width_q - CNT_W'(1);
					end
				end else begin
					pos_q <= pos_nx;
				end
			end else if (issue) begin
				rd_idx_q <= rd_idx_q - IDX_W'(1);
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= item_value;
			rad_q  <= item_radix;
			rem_q  <= '0;
		end else if (state_q == BK_DIV) begin
			quot_q <= quot_nx;
			rem_q  <= div_end ? '0 : rem_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (div_end) begin
			store_mem[cnt_q[IDX_W-1:0]] <= rem_nx;
		end
		if (issue) begin
			rd_data_s1 <= store_mem[rd_idx_q];
			last_s1    <= (rd_idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1  <= 1'b0;
			oq_wp_q  <= 1'b0;
			oq_rp_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			pend_s1 <= issue;
			if (pend_s1) begin
				oq_wp_q <= !oq_wp_q;
			end
			if (pop_fire) begin
				oq_rp_q <= !oq_rp_q;
			end
			unique case ({pend_s1, pop_fire})
				2'b10:   oq_cnt_q <= oq_cnt_q + 2'd1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 2'd1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			oq_char_q[oq_wp_q] <= digit_to_char(rd_data_s1);
			oq_last_q[oq_wp_q] <= last_s1;
		end
	end

endmodule

// File: src/integer_to_radix_digits_top.sv
// integer_to_radix_digits_top: top level of the radix digit converter
// depends on irdig_pkg, irdig_front and irdig_back

// Converts an unsigned value to its digits in a base from two to thirty-six
// (bases below two act as two, above thirty-six as thirty-six) and hands
// them out as ascii '0'-'9' / 'A'-'Z', most significant first, with last set
// on the final digit; zero gives a single '0'. Both sides behave as queues:
// a word goes in on push while full is low, a digit word leaves on pop while
// empty is low. A two-word input queue lets words arrive while a conversion
// runs, and a two-word output queue holds digits until they are taken.
// One conversion at a time: the shared divider takes four quotient bits a
// cycle, each pass over the quotient yielding one digit, and the digits are
// then emitted from the digit store; small values finish far sooner than
// full-width ones.

module integer_to_radix_digits_top
	import irdig_pkg::*;
#(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input side
	input  logic                  push,
	output logic                  full,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]    radix,
	// result side
	output logic                  empty,
	input  logic                  pop,
	output logic [CHAR_W-1:0]     digit_char,
	output logic                  last
);

	// front to back hand-off, base already clamped
	logic                  item_valid;
	logic                  item_ready;
	logic [VALUE_BITS-1:0] item_value;
	logic [RADIX_W-1:0]    item_radix;

	irdig_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.value      (value),
		.radix      (radix),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_value (item_value),
		.item_radix (item_radix)
	);

	// divider, digit store and output queue
	irdig_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_value (item_value),
		.item_radix (item_radix),
		.empty      (empty),
		.pop        (pop),
		.digit_char (digit_char),
		.last       (last)
	);

`ifndef ASSERT_OFF
	// every base reaching the divider lies in the legal range
	a_radix_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |-> (item_radix >= RADIX_MIN && item_radix <= RADIX_MAX))
		else $error("unclamped base reached the divider");

	// a waiting digit word is always a legal character
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((digit_char >= 7'd48 && digit_char <= 7'd57) ||
		            (digit_char >= 7'd65 && digit_char <= 7'd90)))
		else $error("digit word outside '0'-'9' and 'A'-'Z'");

	// a full input queue always offers work to the back end
	a_full_offers: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> item_valid)
		else $error("input queue full but nothing offered");
`endif

endmodule

// File: bench/testbench.sv
// testbench: self-checking bench for the radix digit converter
// needs irdig_pkg and integer_to_radix_digits_top; drives value/radix words in
// and checks every digit word against a digit predictor kept in the bench

module testbench;
	import irdig_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_BITS = 31;
	localparam int NUM_RANDOM = 210;
	localparam int HOLD_CYCLES = 600;
	localparam int LIMIT_CYCLES = 1000000;

	// one value/radix word waiting to be offered
	typedef struct {
		logic [VALUE_BITS-1:0] val;
		logic [RADIX_W-1:0]    base;
		bit                    drain_first;
	} conv_word_t;

	// one expected digit word
	typedef struct packed {
		logic [CHAR_W-1:0] glyph;
		logic              final_digit;
	} digit_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [VALUE_BITS-1:0] value = '0;
	logic [RADIX_W-1:0]    radix = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [CHAR_W-1:0]     digit_char;
	logic                  last;

	conv_word_t  pending_words[$];
	digit_word_t expected_digits[$];

	int          total_words = 0;
	int          words_sent = 0;
	int          error_count = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned cycle_count = 0;
	logic [1:0]  phase = 2'd0;

	// idle chance in percent per phase: sender busy and receiver slow, then swapped, then no idling
	int send_idle_pct[3] = '{27, 67, 0};
	int recv_idle_pct[3] = '{67, 27, 0};

	integer_to_radix_digits_top #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.value     (value),
		.radix     (radix),
		.empty     (empty),
		.pop       (pop),
		.digit_char(digit_char),
		.last      (last)
	);

	always #2 clk = ~clk;

	// works out the digit words of one conversion, most significant first,
	// and appends them to the expected queue
	function automatic void predict_digits(input logic [VALUE_BITS-1:0] num,
			input logic [RADIX_W-1:0] base_in);
		logic [VALUE_BITS-1:0] rest;
		int unsigned           base;
		int unsigned           rems[$];
		int unsigned           d;
		digit_word_t           w;
		// bases outside two to thirty-six act as the nearest end
		if (base_in < 2) begin
			base = 2;
		end else if (base_in > 36) begin
			base = 36;
		end else begin
			base = 32'(base_in);
		end
		rest = num;
		// zero still gives one digit
		do begin
			rems.push_back(rest % base);
			rest = VALUE_BITS'(rest / base);
		end while (rest != 0);
		for (int k = rems.size() - 1; k >= 0; k--) begin
			d = rems[k];
			// '0' is 48, 'A' is 65 = 55 + 10
			w.glyph = (d < 10) ? CHAR_W'(48 + d) : CHAR_W'(55 + d);
			w.final_digit = (k == 0);
			expected_digits.push_back(w);
		end
	endfunction

	task automatic queue_word(input logic [VALUE_BITS-1:0] v, input logic [RADIX_W-1:0] r,
			input bit drain);
		conv_word_t c;
		c.val = v;
		c.base = r;
		c.drain_first = drain;
		pending_words.push_back(c);
	endtask

	// stimulus, reset and the end of the run
	initial begin
		logic [VALUE_BITS-1:0] v;
		logic [RADIX_W-1:0]    r;
		int                    sel;

		// directed: zero, single digits, all-ones at several bases, out-of-range bases
		queue_word('0, 6'd10, 1'b0);
		queue_word('0, 6'd2, 1'b0);
		queue_word('1, 6'd2, 1'b0);
		queue_word('1, 6'd10, 1'b0);
		queue_word('1, 6'd16, 1'b0);
		queue_word('1, 6'd36, 1'b0);
		queue_word('1, 6'd0, 1'b0);
		queue_word('1, 6'd1, 1'b0);
		queue_word('1, 6'd37, 1'b0);
		queue_word('1, 6'd63, 1'b0);
		queue_word(31'd1, 6'd2, 1'b0);
		queue_word(31'd9, 6'd10, 1'b0);
		queue_word(31'd10, 6'd10, 1'b0);
		queue_word(31'd35, 6'd36, 1'b0);
		queue_word(31'd36, 6'd36, 1'b0);
		queue_word(31'd1295, 6'd36, 1'b0);
		queue_word(31'h55555555, 6'd3, 1'b0);
		queue_word(31'h2AAAAAAA, 6'd7, 1'b0);
		queue_word(31'h40000000, 6'd2, 1'b0);
		queue_word(31'd255, 6'd15, 1'b0);

		// random: mostly short values, some full width, now and then a wild base
		for (int i = 0; i < NUM_RANDOM; i++) begin
			sel = $urandom_range(9);
			if (sel < 3) begin
				v = VALUE_BITS'($urandom_range(40));
			end else if (sel < 8) begin
				v = VALUE_BITS'($urandom)
					& ((VALUE_BITS'(1) << $urandom_range(1, 20)) - VALUE_BITS'(1));
			end else begin
				v = VALUE_BITS'($urandom);
			end
			if ($urandom_range(9) < 8) begin
				r = RADIX_W'($urandom_range(2, 36));
			end else begin
				r = RADIX_W'($urandom_range(63));
			end
			// sender waits for the block to drain before the first random word and midway
			queue_word(v, r, (i == 0) || (i == NUM_RANDOM / 2));
		end
		total_words = pending_words.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// sampled on the falling edge so nothing races the clocked blocks
		while (pending_words.size() != 0 || push) @(negedge clk);
		while (expected_digits.size() != 0) @(negedge clk);
		// room for any stray digit word to show up
		repeat (200) @(negedge clk);

		if (expected_digits.size() != 0) begin
			$error("%0d digit words never arrived", expected_digits.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// sender: offers pending words, holds a word while full is high
	always @(posedge clk or negedge arst_n) begin : drive_proc
		conv_word_t nxt;
		if (!arst_n) begin
			push <= 1'b0;
			value <= '0;
			radix <= '0;
		end else begin
			if (push && !full) begin
				predict_digits(value, radix);
				words_sent++;
			end
			if (push && full) begin
				// word not taken yet, keep offering it
			end else if (pending_words.size() != 0
					&& $urandom_range(99) >= send_idle_pct[phase]
					&& (!pending_words[0].drain_first || expected_digits.size() == 0)) begin
				nxt = pending_words.pop_front();
				push <= 1'b1;
				value <= nxt.val;
				radix <= nxt.base;
			end else begin
				push <= 1'b0;
			end
			if (words_sent < total_words / 3) begin
				phase <= 2'd0;
			end else if (words_sent < 2 * total_words / 3) begin
				phase <= 2'd1;
			end else begin
				phase <= 2'd2;
			end
		end
	end

	// receiver: takes digit words and checks them against the oldest expectation
	always @(posedge clk or negedge arst_n) begin : watch_proc
		digit_word_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_digits.size() == 0) begin
					$error("digit word with nothing expected: digit_char %0d last %0d",
						digit_char, last);
					error_count++;
				end else begin
					want = expected_digits.pop_front();
					if (digit_char !== want.glyph) begin
						$error("digit_char: expected %0d, actual %0d", want.glyph, digit_char);
						error_count++;
					end
					if (last !== want.final_digit) begin
						$error("last: expected %0d, actual %0d", want.final_digit, last);
						error_count++;
					end
				end
			end
			// long hold-off once the sender stops idling, so both queues back up
			if (!hold_done && phase == 2'd2) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct[phase]);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
